@@ hdl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion helpers for the parser rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// expression must never hold outside reset
`define ASSERT_NEVER(label, clk, rst_n, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("assertion failed: forbidden condition seen");

// antecedent implies consequent in the same cycle
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: implication violated");

`else

`define ASSERT_NEVER(label, clk, rst_n, expr)
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons)

`endif

`endif

@@ hdl/mfbp_pkg.sv @@
// ----------------------------------------------------------------------------
// mfbp_pkg
// shared types, codes and reset values of the motion frame byte parser
// ----------------------------------------------------------------------------
package mfbp_pkg;

  localparam int MOTOR_COUNT_DEF = 6;
  localparam int MID_DEPTH_DEF   = 4;
  localparam int OUT_DEPTH_DEF   = 4;

  localparam logic [7:0] DIGIT_BASE = 8'h31;

  // configuration register indexes
  localparam logic [2:0] CFG_PREFIX_CODE   = 3'd0;
  localparam logic [2:0] CFG_START_CODE    = 3'd1;
  localparam logic [2:0] CFG_STOP_CODE     = 3'd2;
  localparam logic [2:0] CFG_FRAME_CODE    = 3'd3;
  localparam logic [2:0] CFG_END_CODE      = 3'd4;
  localparam logic [2:0] CFG_VALUE_GAIN    = 3'd5;
  localparam logic [2:0] CFG_HEIGHT_OFFSET = 3'd6;
  localparam logic [2:0] CFG_OUTPUT_ENABLE = 3'd7;

  localparam logic [7:0]  PREFIX_CODE_RST   = 8'd255;
  localparam logic [7:0]  START_CODE_RST    = 8'd83;
  localparam logic [7:0]  STOP_CODE_RST     = 8'd69;
  localparam logic [7:0]  FRAME_CODE_RST    = 8'd70;
  localparam logic [7:0]  END_CODE_RST      = 8'd33;
  localparam logic [23:0] VALUE_GAIN_RST    = 24'd17409;
  localparam logic [14:0] HEIGHT_OFFSET_RST = 15'd8704;

  // run state codes
  localparam logic [1:0] RUN_INITIAL  = 2'd0;
  localparam logic [1:0] RUN_STARTING = 2'd1;
  localparam logic [1:0] RUN_STOPPED  = 2'd2;
  localparam logic [1:0] RUN_RUNNING  = 2'd3;

  typedef struct packed {
    logic [7:0] prefix_code;
    logic [7:0] start_code;
    logic [7:0] stop_code;
    logic [7:0] frame_code;
    logic [7:0] end_code;
    logic       output_enable;
  } mfbp_codes_t;

  typedef struct packed {
    logic [23:0] value_gain;
    logic [14:0] height_offset;
  } mfbp_scale_t;

  // classified byte from the front part
  typedef struct packed {
    logic [1:0]  run_state;
    logic        state_changed;
    logic        frame_accepted;
    logic        value_valid;
    logic [2:0]  motor_index;
    logic [15:0] raw_value;
    logic        index_error;
    logic        frame_done;
  } mfbp_rec_t;

  typedef struct packed {
    logic [1:0]         run_state;
    logic               state_changed;
    logic               frame_accepted;
    logic               value_valid;
    logic [2:0]         motor_index;
    logic [15:0]        raw_value;
    logic signed [15:0] position;
    logic               index_error;
    logic               frame_done;
  } mfbp_res_t;

endpackage

@@ hdl/mfbp_queue.sv @@
// ----------------------------------------------------------------------------
// mfbp_queue
// small register based first-in first-out queue with occupancy count
// ----------------------------------------------------------------------------
module mfbp_queue
  import mfbp_pkg::*;
#(
  parameter int WIDTH = 8,
  parameter int DEPTH = MID_DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  logic [WIDTH-1:0]           push_data,
  output logic                       full,
  input  logic                       pop,
  output logic [WIDTH-1:0]           pop_data,
  output logic                       empty,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_push, do_pop;

  assign full     = (count_r == CW'(DEPTH));
  assign empty    = (count_r == '0);
  assign count    = count_r;
  assign pop_data = slot_r[rd_ptr_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

@@ hdl/mfbp_front.sv @@
// ----------------------------------------------------------------------------
// mfbp_front
// byte classifier: prefix and command parsing, frame phase tracking
// ----------------------------------------------------------------------------
module mfbp_front
  import mfbp_pkg::*;
#(
  parameter int MOTOR_COUNT = MOTOR_COUNT_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  mfbp_codes_t codes,
  input  logic        byte_push,
  input  logic [7:0]  byte_data,
  input  logic        rec_full,
  output logic        rec_push,
  output mfbp_rec_t   rec
);

  localparam int VCW = $clog2(MOTOR_COUNT + 1);

  typedef enum logic [4:0] {
    PH_IDLE  = 5'b00001,
    PH_DIGIT = 5'b00010,
    PH_HIGH  = 5'b00100,
    PH_LOW   = 5'b01000,
    PH_AFTER = 5'b10000
  } phase_t;

  phase_t         phase_r, phase_nxt;
  logic [1:0]     prefix_cnt_r, prefix_cnt_nxt;
  logic [1:0]     run_mode_r, run_mode_nxt;
  logic [VCW-1:0] value_cnt_r, value_cnt_nxt;
  logic [7:0]     index_hold_r, index_hold_nxt;
  logic [7:0]     high_hold_r, high_hold_nxt;
  logic           cmd_go;
  logic [7:0]     idx8;
  logic           take;

  assign take     = byte_push && !rec_full;
  assign rec_push = take;
  assign idx8     = index_hold_r - DIGIT_BASE;

  always_comb begin
    phase_nxt      = phase_r;
    prefix_cnt_nxt = prefix_cnt_r;
    run_mode_nxt   = run_mode_r;
    value_cnt_nxt  = value_cnt_r;
    index_hold_nxt = index_hold_r;
    high_hold_nxt  = high_hold_r;
    cmd_go         = 1'b0;
    rec            = '0;

    case (phase_r)
      PH_DIGIT: begin
        index_hold_nxt = byte_data;
        phase_nxt      = PH_HIGH;
      end
      PH_HIGH: begin
        high_hold_nxt = byte_data;
        phase_nxt     = PH_LOW;
      end
      PH_LOW: begin
        value_cnt_nxt = value_cnt_r + 1'b1;
        phase_nxt     = PH_AFTER;
        if (idx8 >= 8'(MOTOR_COUNT)) begin
          rec.index_error = 1'b1;
        end else begin
          rec.value_valid = 1'b1;
          rec.motor_index = idx8[2:0];
          rec.raw_value   = {high_hold_r, byte_data};
        end
      end
      PH_AFTER: begin
        if (byte_data == codes.end_code) begin
          rec.frame_done = 1'b1;
          phase_nxt      = PH_IDLE;
          cmd_go         = 1'b1;
        end else if (value_cnt_r < VCW'(MOTOR_COUNT)) begin
          index_hold_nxt = byte_data;
          phase_nxt      = PH_HIGH;
        end else begin
          phase_nxt = PH_IDLE;
          cmd_go    = 1'b1;
        end
      end
      default: begin
        phase_nxt = PH_IDLE;
        cmd_go    = 1'b1;
      end
    endcase

    // command parser, also sees the byte that closes a frame
    if (cmd_go) begin
      if (byte_data == codes.prefix_code) begin
        prefix_cnt_nxt = (prefix_cnt_r != 2'd0) ? 2'd2 : 2'd1;
      end else begin
        prefix_cnt_nxt = 2'd0;
        if (prefix_cnt_r == 2'd2) begin
          if (byte_data == codes.start_code) begin
            run_mode_nxt = RUN_STARTING;
          end else if (byte_data == codes.stop_code) begin
            run_mode_nxt = RUN_STOPPED;
          end else if (byte_data == codes.frame_code && codes.output_enable) begin
            run_mode_nxt       = RUN_RUNNING;
            phase_nxt          = PH_DIGIT;
            value_cnt_nxt      = '0;
            rec.frame_accepted = 1'b1;
          end
        end
      end
    end

    rec.run_state     = run_mode_nxt;
    rec.state_changed = (run_mode_nxt != run_mode_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      prefix_cnt_r <= '0;
      run_mode_r   <= RUN_INITIAL;
      value_cnt_r  <= '0;
      index_hold_r <= '0;
      high_hold_r  <= '0;
    end else if (take) begin
      phase_r      <= phase_nxt;
      prefix_cnt_r <= prefix_cnt_nxt;
      run_mode_r   <= run_mode_nxt;
      value_cnt_r  <= value_cnt_nxt;
      index_hold_r <= index_hold_nxt;
      high_hold_r  <= high_hold_nxt;
    end
  end

endmodule

@@ hdl/mfbp_back.sv @@
// ----------------------------------------------------------------------------
// mfbp_back
// value scaling: multiply stage, round, offset and saturate, result queue
// ----------------------------------------------------------------------------
module mfbp_back
  import mfbp_pkg::*;
#(
  parameter int OUT_DEPTH = OUT_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  mfbp_scale_t scale,
  input  logic        rec_empty,
  input  mfbp_rec_t   rec,
  output logic        rec_pop,
  input  logic        res_pop,
  output logic        res_empty,
  output mfbp_res_t   res
);

  localparam int CW = $clog2(OUT_DEPTH + 1);

  logic               s1_valid_r;
  mfbp_rec_t          s1_rec_r;
  logic [39:0]        s1_prod_r;
  logic [40:0]        rounded;
  logic [24:0]        scaled;
  logic signed [25:0] diff;
  logic signed [15:0] sat;
  mfbp_res_t          res_in;
  logic [CW-1:0]      res_count;
  logic [CW:0]        reserved;
  logic               res_full;

  // slot in the result queue is reserved before a transaction enters the stage
  assign reserved = {1'b0, res_count} + (CW+1)'(s1_valid_r);
  assign rec_pop  = !rec_empty && !res_full && (reserved < (CW+1)'(OUT_DEPTH));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= rec_pop;
    end
  end

  always_ff @(posedge clk) begin
    if (rec_pop) begin
      s1_rec_r  <= rec;
      s1_prod_r <= scale.value_gain * rec.raw_value;
    end
  end

  always_comb begin
    rounded = {1'b0, s1_prod_r} + 41'(1 << 15);
    scaled  = rounded[40:16];
    diff    = $signed({1'b0, scaled}) - $signed({11'b0, scale.height_offset});
    if (diff > 26'sd32767) begin
      sat = 16'sh7FFF;
    end else if (diff < -26'sd32768) begin
      sat = 16'sh8000;
    end else begin
      sat = diff[15:0];
    end
    res_in.run_state      = s1_rec_r.run_state;
    res_in.state_changed  = s1_rec_r.state_changed;
    res_in.frame_accepted = s1_rec_r.frame_accepted;
    res_in.value_valid    = s1_rec_r.value_valid;
    res_in.motor_index    = s1_rec_r.motor_index;
    res_in.raw_value      = s1_rec_r.raw_value;
    res_in.position       = s1_rec_r.value_valid ? sat : 16'sd0;
    res_in.index_error    = s1_rec_r.index_error;
    res_in.frame_done     = s1_rec_r.frame_done;
  end

  mfbp_queue #(
    .WIDTH ($bits(mfbp_res_t)),
    .DEPTH (OUT_DEPTH)
  ) u_res_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (s1_valid_r),
    .push_data (res_in),
    .full      (res_full),
    .pop       (res_pop),
    .pop_data  (res),
    .empty     (res_empty),
    .count     (res_count)
  );

endmodule

@@ hdl/motion_frame_byte_parser.sv @@
// ----------------------------------------------------------------------------
// motion_frame_byte_parser
// serial byte parser for run commands and motor value frames
// ----------------------------------------------------------------------------
// Takes one received byte per clock and returns exactly one result per byte,
// in order. A new byte is accepted every cycle while in_full is low; a result
// passes the middle queue, multiply stage and result queue, then stays on the
// out_ ports until popped. Throughput is set by the scaling unit, one 24 x 16
// multiply per cycle while the result queue has room. Bytes are classified by
// the front part and queued (MID_DEPTH entries) ahead of the scaling unit,
// whose results wait in an OUT_DEPTH entry queue. Configuration writes are
// always ready and must be issued while idle.
module motion_frame_byte_parser
  import mfbp_pkg::*;
#(
  parameter int MOTOR_COUNT = MOTOR_COUNT_DEF,
  parameter int MID_DEPTH   = MID_DEPTH_DEF,
  parameter int OUT_DEPTH   = OUT_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  input  logic [7:0]         in_rx_byte,
  output logic               in_full,
  output logic               out_empty,
  input  logic               out_pop,
  output logic [1:0]         out_run_state,
  output logic               out_state_changed,
  output logic               out_frame_accepted,
  output logic               out_value_valid,
  output logic [2:0]         out_motor_index,
  output logic [15:0]        out_raw_value,
  output logic signed [15:0] out_position,
  output logic               out_index_error,
  output logic               out_frame_done,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [23:0]        cfg_data
);

  `include "assert_macros.svh"

  mfbp_codes_t codes_r;
  mfbp_scale_t scale_r;
  logic        rec_push;
  mfbp_rec_t   rec_in;
  mfbp_rec_t   rec_out;
  logic        rec_full;
  logic        rec_empty;
  logic        rec_pop;
  logic [$clog2(MID_DEPTH+1)-1:0] rec_count;
  mfbp_res_t   res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      codes_r.prefix_code   <= PREFIX_CODE_RST;
      codes_r.start_code    <= START_CODE_RST;
      codes_r.stop_code     <= STOP_CODE_RST;
      codes_r.frame_code    <= FRAME_CODE_RST;
      codes_r.end_code      <= END_CODE_RST;
      codes_r.output_enable <= 1'b0;
      scale_r.value_gain    <= VALUE_GAIN_RST;
      scale_r.height_offset <= HEIGHT_OFFSET_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_PREFIX_CODE:   codes_r.prefix_code   <= cfg_data[7:0];
        CFG_START_CODE:    codes_r.start_code    <= cfg_data[7:0];
        CFG_STOP_CODE:     codes_r.stop_code     <= cfg_data[7:0];
        CFG_FRAME_CODE:    codes_r.frame_code    <= cfg_data[7:0];
        CFG_END_CODE:      codes_r.end_code      <= cfg_data[7:0];
        CFG_VALUE_GAIN:    scale_r.value_gain    <= cfg_data;
        CFG_HEIGHT_OFFSET: scale_r.height_offset <= cfg_data[14:0];
        CFG_OUTPUT_ENABLE: codes_r.output_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  mfbp_front #(
    .MOTOR_COUNT (MOTOR_COUNT)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .codes     (codes_r),
    .byte_push (in_push),
    .byte_data (in_rx_byte),
    .rec_full  (rec_full),
    .rec_push  (rec_push),
    .rec       (rec_in)
  );

  assign in_full = rec_full;

  mfbp_queue #(
    .WIDTH ($bits(mfbp_rec_t)),
    .DEPTH (MID_DEPTH)
  ) u_mid_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (rec_push),
    .push_data (rec_in),
    .full      (rec_full),
    .pop       (rec_pop),
    .pop_data  (rec_out),
    .empty     (rec_empty),
    .count     (rec_count)
  );

  mfbp_back #(
    .OUT_DEPTH (OUT_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .scale     (scale_r),
    .rec_empty (rec_empty),
    .rec       (rec_out),
    .rec_pop   (rec_pop),
    .res_pop   (out_pop),
    .res_empty (out_empty),
    .res       (res)
  );

  assign out_run_state      = res.run_state;
  assign out_state_changed  = res.state_changed;
  assign out_frame_accepted = res.frame_accepted;
  assign out_value_valid    = res.value_valid;
  assign out_motor_index    = res.motor_index;
  assign out_raw_value      = res.raw_value;
  assign out_position       = res.position;
  assign out_index_error    = res.index_error;
  assign out_frame_done     = res.frame_done;

  `ASSERT_NEVER(a_pop_on_empty, clk, rst_n, rec_pop && rec_empty)
  `ASSERT_NEVER(a_count_full_mismatch, clk, rst_n, rec_full && (rec_count == '0))
  `ASSERT_IMPLY(a_frame_runs, clk, rst_n, rec_push && rec_in.frame_accepted, rec_in.run_state == RUN_RUNNING)
  `ASSERT_NEVER(a_valid_and_error, clk, rst_n, rec_push && rec_in.value_valid && rec_in.index_error)

endmodule
